// ===== sv/tdq_pkg.sv =====
`timescale 1ns / 1ps

package tdq_pkg;

    // Queue geometry.
    localparam int CAPACITY     = 256;
    localparam int TASK_ID_BITS = 16;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Fixed field widths of the item and result.
    localparam int TIME_W    = 64;
    localparam int TASK_W    = 16;
    localparam int BUDGET_W  = 7;
    localparam int PENDING_W = 9;

    localparam logic [BUDGET_W-1:0]     MAX_FIRE       = BUDGET_W'(64);
    localparam logic signed [TIME_W-1:0] NEVER_DEADLINE = {1'b0, {(TIME_W-1){1'b1}}};

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [TIME_W-1:0] deadline;
        logic [TASK_W-1:0]        task_id;
        logic signed [TIME_W-1:0] now;
        logic [BUDGET_W-1:0]      budget;
    } in_item_t;

    typedef struct packed {
        logic [TASK_W-1:0]        fired_task;
        logic                     fired;
        logic                     more_due;
        logic signed [TIME_W-1:0] next_deadline;
        logic [PENDING_W-1:0]     pending;
        logic                     overflow;
        logic                     last;
    } out_item_t;

    // One stored timer.
    typedef struct packed {
        logic signed [TIME_W-1:0] deadline;
        logic [TASK_ID_BITS-1:0]  task_id;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_POP
    } cell_cmd_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_cmd_t cmd;
        entry_t    new_entry;
    } cell_ctrl_t;

endpackage

// ===== sv/tdq_cell.sv =====
`timescale 1ns / 1ps

module tdq_cell (
    input  logic                clk,
    input  tdq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  tdq_pkg::entry_t     prev_entry,
    input  logic                prev_keeps,
    input  tdq_pkg::entry_t     next_entry,
    output tdq_pkg::entry_t     entry,
    output logic                keeps
);
    import tdq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // An occupied entry that is due no later than the new one stays put, so
    // equal deadlines keep their arrival order.
    assign keeps = occupied &&
                   ($signed(entry_reg.deadline) <= $signed(ctrl.new_entry.deadline));

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                if (!keeps)
                begin
                    entry_next = prev_keeps ? ctrl.new_entry : prev_entry;
                end
            end
            CMD_POP:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== sv/tdq_array.sv =====
`timescale 1ns / 1ps

module tdq_array (
    input  logic                          clk,
    input  tdq_pkg::cell_ctrl_t           ctrl,
    input  logic [tdq_pkg::CNT_W-1:0]     count,
    output tdq_pkg::entry_t               head_entry,
    output tdq_pkg::entry_t               second_entry
);
    import tdq_pkg::*;

    entry_t entries [CAPACITY];
    logic   keeps   [CAPACITY];

    // Cell 0 holds the earliest entry. Entries at or beyond the count are
    // stale: they still shift with the row, but never count as stored.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic   occupied;
        logic   prev_keeps;
        entry_t prev_entry;
        entry_t next_entry;

        assign occupied = count > CNT_W'(i);

        if (i == 0)
        begin : g_first
            assign prev_keeps = 1'b1;
            assign prev_entry = ctrl.new_entry;
        end
        else
        begin : g_inner
            assign prev_keeps = keeps[i-1];
            assign prev_entry = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_entry = entries[i];
        end
        else
        begin : g_body
            assign next_entry = entries[i+1];
        end

        tdq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .prev_entry (prev_entry),
            .prev_keeps (prev_keeps),
            .next_entry (next_entry),
            .entry      (entries[i]),
            .keeps      (keeps[i])
        );
    end

    assign head_entry   = entries[0];
    assign second_entry = entries[1];

endmodule

// ===== sv/timer_deadline_queue.sv =====
`timescale 1ns / 1ps
// An add item gives its single result from the add state, through the result register.
// A drain item gives its results from the drain state through the same register, one result per cycle.
// The block takes a new item only when idle, once the previous item's last result is registered.
// The sorted row of cells inserts or removes one entry per cycle.
// Reset empties the queue and idles the controller; stored payload is not cleared.
// Results are strobed for one cycle and the receiver cannot stall them.

module timer_deadline_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tdq_pkg::in_item_t  req,
    output logic               done,
    output tdq_pkg::out_item_t result
);
    import tdq_pkg::*;

    // The controller walks one item at a time. An add is one insertion step;
    // a drain pops the head once per cycle while it is due and budget remains.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_DRAIN
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [BUDGET_W-1:0]       fired_reg, fired_next;
    logic [BUDGET_W-1:0]       budget_reg, budget_next;
    logic signed [TIME_W-1:0]  deadline_reg, deadline_next;
    logic signed [TIME_W-1:0]  now_reg, now_next;
    logic [TASK_ID_BITS-1:0]   task_reg, task_next;
    logic                      done_reg, done_next;
    out_item_t                 result_reg, result_next;

    cell_ctrl_t ctrl;
    entry_t     head_entry;
    entry_t     second_entry;

    logic head_valid;
    logic second_valid;
    logic head_due;
    logic second_due;
    logic full;
    logic can_fire;
    logic fire_last;

    // The row of cells keeps entries sorted by deadline, earliest in cell 0.
    tdq_array u_array (
        .clk          (clk),
        .ctrl         (ctrl),
        .count        (count_reg),
        .head_entry   (head_entry),
        .second_entry (second_entry)
    );

    assign head_valid   = count_reg != '0;
    assign second_valid = count_reg > CNT_W'(1);
    assign head_due     = head_valid && ($signed(head_entry.deadline) <= now_reg);
    assign second_due   = second_valid && ($signed(second_entry.deadline) <= now_reg);
    assign full         = count_reg == CNT_W'(CAPACITY);
    assign can_fire     = head_due && (fired_reg < budget_reg);

    // After this pop, the drain stops if the budget is spent or the new head
    // is not due. That lets the final result carry its last mark at once.
    assign fire_last = (fired_reg + BUDGET_W'(1) == budget_reg) || !second_due;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        fired_next    = fired_reg;
        budget_next   = budget_reg;
        deadline_next = deadline_reg;
        now_next      = now_reg;
        task_next     = task_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        ctrl.cmd                = CMD_HOLD;
        ctrl.new_entry.deadline = deadline_reg;
        ctrl.new_entry.task_id  = task_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    deadline_next = req.deadline;
                    now_next      = req.now;
                    task_next     = TASK_ID_BITS'(req.task_id);
                    budget_next   = (req.budget > MAX_FIRE) ? MAX_FIRE : req.budget;
                    fired_next    = '0;
                    state_next    = (req.mode == MODE_DRAIN) ? ST_DRAIN : ST_ADD;
                end
            end

            ST_ADD:
            begin
                result_next.fired_task = '0;
                result_next.fired      = 1'b0;
                result_next.more_due   = 1'b0;
                result_next.last       = 1'b1;
                result_next.overflow   = full;
                if (full)
                begin
                    // The queue is full: the item is dropped.
                    result_next.pending       = PENDING_W'(count_reg);
                    result_next.next_deadline = head_entry.deadline;
                end
                else
                begin
                    ctrl.cmd   = CMD_INSERT;
                    count_next = count_reg + CNT_W'(1);
                    result_next.pending = PENDING_W'(count_next);
                    if (!head_valid || ($signed(head_entry.deadline) > deadline_reg))
                    begin
                        result_next.next_deadline = deadline_reg;
                    end
                    else
                    begin
                        result_next.next_deadline = head_entry.deadline;
                    end
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_DRAIN:
            begin
                result_next.overflow = 1'b0;
                if (can_fire)
                begin
                    ctrl.cmd   = CMD_POP;
                    count_next = count_reg - CNT_W'(1);
                    fired_next = fired_reg + BUDGET_W'(1);
                    result_next.fired_task    = TASK_W'(head_entry.task_id);
                    result_next.fired         = 1'b1;
                    result_next.more_due      = second_due;
                    result_next.next_deadline = second_valid ? second_entry.deadline
                                                             : NEVER_DEADLINE;
                    result_next.pending       = PENDING_W'(count_next);
                    result_next.last          = fire_last;
                    if (fire_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // Nothing fires at all: one status result.
                    result_next.fired_task    = '0;
                    result_next.fired         = 1'b0;
                    result_next.more_due      = head_due;
                    result_next.next_deadline = head_valid ? head_entry.deadline
                                                           : NEVER_DEADLINE;
                    result_next.pending       = PENDING_W'(count_reg);
                    result_next.last          = 1'b1;
                    state_next                = ST_IDLE;
                end
                done_next = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the result strobe are reset; item and result payload
    // registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            fired_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fired_reg <= fired_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        budget_reg   <= budget_next;
        deadline_reg <= deadline_next;
        now_reg      <= now_next;
        task_reg     <= task_next;
        result_reg   <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sim/tb_timer_deadline_queue.sv =====
`timescale 1ns / 1ps

module tb_timer_deadline_queue;

    import tdq_pkg::*;

    localparam logic [TASK_W-1:0] TASK_MASK =
        TASK_W'((64'd1 << TASK_ID_BITS) - 64'd1);
    localparam logic signed [TIME_W-1:0] EARLIEST_TIME = {1'b1, {(TIME_W-1){1'b0}}};
    localparam int unsigned RANDOM_ITEMS = 120;
    localparam int unsigned PRINT_LIMIT  = 60;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  req;
    logic      done;
    out_item_t result;

    timer_deadline_queue u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // Shadow copy of the timer store. Entries are kept unsorted; the head is
    // found by a scan over (deadline, arrival stamp), and a removed entry is
    // back-filled from the top slot.
    logic signed [TIME_W-1:0] timer_deadline [CAPACITY];
    logic [63:0]              timer_order    [CAPACITY];
    logic [TASK_W-1:0]        timer_task     [CAPACITY];
    int unsigned              timer_count;
    logic [63:0]              order_stamp;

    // Results the block still owes, oldest first.
    out_item_t                awaited_results [$];
    out_item_t                want;
    int unsigned              error_count;

    // When set, the sender offers items back to back.
    bit                       no_idle;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Slot of the earliest entry; ties go to the lower arrival stamp.
    function automatic int unsigned earliest_slot();
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i < timer_count; i++) begin
            if (timer_deadline[i] < timer_deadline[best] ||
                (timer_deadline[i] == timer_deadline[best] &&
                 timer_order[i] < timer_order[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic logic head_due(logic signed [TIME_W-1:0] now);
        return (timer_count != 0) && (timer_deadline[earliest_slot()] <= now);
    endfunction

    // Queues one expected result; head and count reflect the store as it is now.
    function automatic void queue_result(logic [TASK_W-1:0] task_id, logic fired,
                                         logic more_due, logic overflow, logic last);
        out_item_t r;
        r.fired_task    = task_id;
        r.fired         = fired;
        r.more_due      = more_due;
        r.next_deadline = (timer_count != 0) ? timer_deadline[earliest_slot()]
                                             : NEVER_DEADLINE;
        r.pending       = PENDING_W'(timer_count);
        r.overflow      = overflow;
        r.last          = last;
        awaited_results.push_back(r);
    endfunction

    // Applies one item to the shadow store and queues every result it causes.
    function automatic void predict_timer_step(in_item_t it);
        int unsigned       limit;
        int unsigned       fired_n;
        int unsigned       h;
        logic [TASK_W-1:0] t;
        logic              more;
        if (it.mode == MODE_ADD) begin
            if (timer_count >= CAPACITY) begin
                // Full: the entry is dropped and the stamp does not advance.
                queue_result('0, 1'b0, 1'b0, 1'b1, 1'b1);
            end else begin
                timer_deadline[timer_count] = it.deadline;
                timer_order[timer_count]    = order_stamp;
                timer_task[timer_count]     = it.task_id & TASK_MASK;
                order_stamp++;
                timer_count++;
                queue_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
        end else begin
            limit   = (it.budget > MAX_FIRE) ? int'(MAX_FIRE) : int'(it.budget);
            fired_n = 0;
            while (fired_n < limit && head_due(it.now)) begin
                h = earliest_slot();
                t = timer_task[h];
                timer_count--;
                if (h != timer_count) begin
                    timer_deadline[h] = timer_deadline[timer_count];
                    timer_order[h]    = timer_order[timer_count];
                    timer_task[h]     = timer_task[timer_count];
                end
                more = head_due(it.now);
                // The drain stops after this one unless another is due and budget remains.
                queue_result(t, 1'b1, more, 1'b0, !(more && (fired_n + 1 < limit)));
                fired_n++;
            end
            if (fired_n == 0)
                queue_result('0, 1'b0, head_due(it.now), 1'b0, 1'b1);
        end
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] wanted);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, wanted);
    endtask

    // Results are sampled at the rising edge that ends their strobe cycle.
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no item outstanding",
                                64'(result.fired_task), 64'd0);
            end else begin
                want = awaited_results.pop_front();
                if (result.fired_task !== want.fired_task)
                    report_mismatch("fired_task", 64'(result.fired_task),
                                    64'(want.fired_task));
                if (result.fired !== want.fired)
                    report_mismatch("fired", 64'(result.fired), 64'(want.fired));
                if (result.more_due !== want.more_due)
                    report_mismatch("more_due", 64'(result.more_due), 64'(want.more_due));
                if (result.next_deadline !== want.next_deadline)
                    report_mismatch("next_deadline", result.next_deadline,
                                    want.next_deadline);
                if (result.pending !== want.pending)
                    report_mismatch("pending", 64'(result.pending), 64'(want.pending));
                if (result.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(result.overflow), 64'(want.overflow));
                if (result.last !== want.last)
                    report_mismatch("last", 64'(result.last), 64'(want.last));
            end
        end
    end

    function automatic in_item_t random_item();
        in_item_t it;
        it.mode     = 1'($urandom);
        it.deadline = {$urandom, $urandom};
        it.task_id  = TASK_W'($urandom);
        it.now      = {$urandom, $urandom};
        it.budget   = BUDGET_W'($urandom);
        return it;
    endfunction

    // Fields an add does not use stay random so that the block is seen to ignore them.
    function automatic in_item_t add_item(logic signed [TIME_W-1:0] deadline,
                                          logic [TASK_W-1:0] task_id);
        in_item_t it;
        it          = random_item();
        it.mode     = MODE_ADD;
        it.deadline = deadline;
        it.task_id  = task_id;
        return it;
    endfunction

    function automatic in_item_t drain_item(logic signed [TIME_W-1:0] now,
                                            logic [BUDGET_W-1:0] budget);
        in_item_t it;
        it        = random_item();
        it.mode   = MODE_DRAIN;
        it.now    = now;
        it.budget = budget;
        return it;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic idle_gap(int unsigned cycles);
        repeat (cycles) begin
            @(negedge clk);
            start <= 1'b0;
            req   <= random_item();
        end
    endtask

    // Offers one item and returns at the rising edge that accepts it. Start is
    // left high so that a following item can go out without a gap.
    task automatic send_item(in_item_t item);
        if (!no_idle)
            idle_gap(pick_gap());
        @(negedge clk);
        start <= 1'b1;
        req   <= item;
        predict_timer_step(item);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Empty queue, zero and saturated budgets, the extreme deadlines, ties fired
    // in arrival order, and a deadline exactly equal to now.
    task automatic test_directed_cases();
        send_item(drain_item(EARLIEST_TIME, 7'd127));
        send_item(drain_item(64'sd0, 7'd0));
        send_item(add_item(EARLIEST_TIME, 16'h0000));
        send_item(add_item(NEVER_DEADLINE, 16'hFFFF));
        send_item(add_item(64'sd100, 16'h0001));
        send_item(add_item(64'sd100, 16'h0002));
        send_item(add_item(64'sd100, 16'h0003));
        send_item(add_item(-64'sd5, 16'h0004));
        send_item(drain_item(64'sd99, 7'd0));
        send_item(drain_item(64'sd99, 7'd1));
        send_item(drain_item(64'sd100, 7'd127));
        send_item(drain_item(64'sd100, 7'd64));
        send_item(drain_item(NEVER_DEADLINE, 7'd64));
        send_item(add_item(EARLIEST_TIME, 16'h5A5A));
        send_item(drain_item(EARLIEST_TIME, 7'd1));
        send_item(drain_item(NEVER_DEADLINE, 7'd64));
        wait_for_results();
    endtask

    // Fills the queue with deadlines from 0 to 15, so ties are common, pushes
    // past capacity, and then empties it with full-budget drains.
    task automatic test_fill_and_overflow();
        while (timer_count < CAPACITY)
            send_item(add_item(64'($urandom_range(0, 15)), TASK_W'($urandom)));
        send_item(add_item(EARLIEST_TIME, TASK_W'($urandom)));
        send_item(add_item(NEVER_DEADLINE, TASK_W'($urandom)));
        send_item(add_item(64'sd3, TASK_W'($urandom)));
        send_item(drain_item(64'sd7, 7'd64));
        while (timer_count != 0)
            send_item(drain_item(NEVER_DEADLINE, $urandom_range(0, 1) ? 7'd64 : 7'd127));
        wait_for_results();
    endtask

    // Adds and drains around a running clock, so that most drains fire something,
    // with some extreme and fully random times mixed in.
    task automatic test_random_traffic();
        logic signed [TIME_W-1:0] clock_ns;
        logic signed [TIME_W-1:0] recent_deadline;
        in_item_t                 it;
        int unsigned              r;
        int unsigned              burst_left;
        clock_ns        = -64'sd2000;
        recent_deadline = clock_ns;
        burst_left      = 0;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0 && $urandom_range(0, 39) == 0)
                burst_left = $urandom_range(10, 30);
            no_idle = (burst_left != 0);
            if (burst_left != 0)
                burst_left--;
            // Let the block run dry once, at item 60, before going on.
            if (n % 100 == 60)
                wait_for_results();
            it = random_item();
            r  = $urandom_range(0, 99);
            if (r < ((timer_count < 32) ? 60 : 40)) begin
                it.mode = MODE_ADD;
                r = $urandom_range(0, 99);
                if (r < 78)
                    it.deadline = clock_ns + 64'($urandom_range(0, 300)) - 64'sd100;
                else if (r < 88)
                    it.deadline = recent_deadline;
                else if (r < 91)
                    it.deadline = EARLIEST_TIME;
                else if (r < 94)
                    it.deadline = NEVER_DEADLINE;
                recent_deadline = it.deadline;
            end else begin
                it.mode = MODE_DRAIN;
                r = $urandom_range(0, 99);
                if (r < 88)
                    it.now = clock_ns;
                else if (r < 91)
                    it.now = EARLIEST_TIME;
                else if (r < 94)
                    it.now = NEVER_DEADLINE;
                r = $urandom_range(0, 99);
                if (r < 10)
                    it.budget = '0;
                else if (r < 75)
                    it.budget = BUDGET_W'($urandom_range(1, 8));
                else if (r < 90)
                    it.budget = BUDGET_W'($urandom_range(9, 64));
                else
                    it.budget = BUDGET_W'($urandom_range(65, 127));
            end
            send_item(it);
            clock_ns = clock_ns + 64'($urandom_range(0, 60));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        error_count = 0;
        no_idle     = 1'b0;
        timer_count = 0;
        order_stamp = '0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_fill_and_overflow();
        test_random_traffic();

        wait_for_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Far beyond the slowest correct run: every item with a long gap and a full drain.
    initial begin
        #(5_000_000);
        $display("run timed out with %0d results outstanding", awaited_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
